@@ design/gtm_pkg.sv @@
// ----------------------------------------------------------------------------
// gtm_pkg: shared definitions for the Goertzel tone magnitude block
// Widths of the recurrence stores, the serial units and the sequencer states.
// ----------------------------------------------------------------------------
package gtm_pkg;

   // input sample port width and default significant bits
   localparam int SAMPLE_W            = 16;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // coefficient register
   localparam int                 COEFF_W     = 9;
   localparam logic [COEFF_W-1:0] COEFF_RESET = 9'd154;

   // recurrence stores and serial multiplier
   localparam int Q_W     = 32;
   localparam int MCAND_W = COEFF_W + Q_W;   // multiplicand width
   localparam int PROD_W  = MCAND_W + Q_W;   // full product width
   localparam int SQ_W    = 2 * Q_W;         // sum of squares width

   // divide by the coefficient scale
   localparam int DIVISOR = 100;
   localparam int REM_W   = 7;

   // power and magnitude
   localparam int POWER_W = 32;
   localparam int ROOT_W  = POWER_W / 2;
   localparam int MAG_W   = 16;

   // divider command
   typedef struct packed {
      logic start;
      logic wide;   // full-width dividend, else the narrow recurrence product
   } div_cmd_type;

   // sequencer states
   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_REC_MUL  = 12'b0000_0000_0010,
      ST_REC_DIV  = 12'b0000_0000_0100,
      ST_REC_SUM  = 12'b0000_0000_1000,
      ST_PWR_SQ1  = 12'b0000_0001_0000,
      ST_PWR_SQ2  = 12'b0000_0010_0000,
      ST_PWR_CQ2  = 12'b0000_0100_0000,
      ST_PWR_CQ12 = 12'b0000_1000_0000,
      ST_PWR_DIV  = 12'b0001_0000_0000,
      ST_PWR_SUM  = 12'b0010_0000_0000,
      ST_ROOT     = 12'b0100_0000_0000,
      ST_OUT      = 12'b1000_0000_0000
   } state_type;

endpackage

@@ design/gtm_mul.sv @@
// ----------------------------------------------------------------------------
// gtm_mul: serial unsigned multiplier
// Shift-add, one multiplier bit per cycle, LSB first; product held until the
// next start.
// ----------------------------------------------------------------------------
module gtm_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [gtm_pkg::MCAND_W-1:0]  mcand,
   input  logic [gtm_pkg::Q_W-1:0]      mplr,
   output logic                         done,
   output logic [gtm_pkg::PROD_W-1:0]   product
);

   localparam int                CNT_W     = $clog2(gtm_pkg::Q_W);
   localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(gtm_pkg::Q_W - 1);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [gtm_pkg::MCAND_W-1:0]  mcand_ff, mcand_in;
   logic [gtm_pkg::MCAND_W-1:0]  hi_ff, hi_in;
   logic [gtm_pkg::Q_W-1:0]      lo_ff, lo_in;
   logic [gtm_pkg::MCAND_W:0]    sum;

   // partial product add on the low multiplier bit
   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         mcand_in = mcand;
         hi_in    = '0;
         lo_in    = mplr;
      end else if (busy_ff) begin
         count_in = count_ff + 1'b1;
         hi_in    = sum[gtm_pkg::MCAND_W:1];
         lo_in    = {sum[0], lo_ff[gtm_pkg::Q_W-1:1]};
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

@@ design/gtm_div100.sv @@
// ----------------------------------------------------------------------------
// gtm_div100: serial divide by the coefficient scale
// Restoring division, one quotient bit per cycle, MSB first; the remainder
// stays below the divisor so the compare is narrow.
// ----------------------------------------------------------------------------
module gtm_div100 (
   input  logic                        clock,
   input  logic                        reset,
   input  gtm_pkg::div_cmd_type        cmd,
   input  logic [gtm_pkg::PROD_W-1:0]  dividend,
   output logic                        done,
   output logic [gtm_pkg::PROD_W-1:0]  quotient
);

   localparam int                CNT_W       = $clog2(gtm_pkg::PROD_W);
   localparam int                ALIGN       = gtm_pkg::PROD_W - gtm_pkg::MCAND_W;
   localparam logic [CNT_W-1:0]  LAST_WIDE   = CNT_W'(gtm_pkg::PROD_W - 1);
   localparam logic [CNT_W-1:0]  LAST_NARROW = CNT_W'(gtm_pkg::MCAND_W - 1);
   localparam logic [gtm_pkg::REM_W:0] DIV_K = (gtm_pkg::REM_W + 1)'(gtm_pkg::DIVISOR);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [CNT_W-1:0]             last_ff, last_in;
   logic [gtm_pkg::REM_W-1:0]    rem_ff, rem_in;
   logic [gtm_pkg::PROD_W-1:0]   shift_ff, shift_in;
   logic [gtm_pkg::REM_W:0]      trial;
   logic [gtm_pkg::REM_W:0]      diff;
   logic                         ge;

   // one restoring step
   assign trial = {rem_ff, shift_ff[gtm_pkg::PROD_W-1]};
   assign ge    = (trial >= DIV_K);
   assign diff  = trial - DIV_K;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      last_in  = last_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         // narrow dividends are moved to the top so only their bits are walked
         if (cmd.wide) begin
            shift_in = dividend;
            last_in  = LAST_WIDE;
         end else begin
            shift_in = dividend << ALIGN;
            last_in  = LAST_NARROW;
         end
      end else if (busy_ff) begin
         count_in = count_ff + 1'b1;
         rem_in   = ge ? diff[gtm_pkg::REM_W-1:0] : trial[gtm_pkg::REM_W-1:0];
         shift_in = {shift_ff[gtm_pkg::PROD_W-2:0], ge};
         if (count_ff == last_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      last_ff  <= last_in;
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
   end

   assign done     = done_ff;
   assign quotient = shift_ff;

endmodule

@@ design/gtm_sqrt.sv @@
// ----------------------------------------------------------------------------
// gtm_sqrt: serial floor square root
// Two radicand bits in and one root bit out per cycle.
// ----------------------------------------------------------------------------
module gtm_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [gtm_pkg::POWER_W-1:0]  radicand,
   output logic                         done,
   output logic [gtm_pkg::ROOT_W-1:0]   root
);

   localparam int                CNT_W     = $clog2(gtm_pkg::ROOT_W);
   localparam int                REMW      = gtm_pkg::ROOT_W + 1;
   localparam int                CANDW     = REMW + 2;
   localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(gtm_pkg::ROOT_W - 1);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [gtm_pkg::POWER_W-1:0]  rad_ff, rad_in;
   logic [REMW-1:0]              rem_ff, rem_in;
   logic [gtm_pkg::ROOT_W-1:0]   root_ff, root_in;
   logic [CANDW-1:0]             cand;
   logic [CANDW-1:0]             trial;
   logic [CANDW-1:0]             diff;
   logic                         ge;

   // remainder with next bit pair against 4r+1
   assign cand  = {rem_ff, rad_ff[gtm_pkg::POWER_W-1 -: 2]};
   assign trial = {1'b0, root_ff, 2'b01};
   assign ge    = (cand >= trial);
   assign diff  = cand - trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rad_in   = radicand;
         rem_in   = '0;
         root_in  = '0;
      end else if (busy_ff) begin
         count_in = count_ff + 1'b1;
         rad_in   = {rad_ff[gtm_pkg::POWER_W-3:0], 2'b00};
         rem_in   = ge ? diff[REMW-1:0] : cand[REMW-1:0];
         root_in  = {root_ff[gtm_pkg::ROOT_W-2:0], ge};
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ design/goertzel_tone_magnitude.sv @@
// A sample without the last flag occupies the block for its recurrence steps
// (multiply, divide, sum). A sample that closes a block gives its magnitude word
// after the power and root steps too; the next sample is taken in the cycle the word appears.
// The pace is set by the bit-serial multiplier and the serial divide by 100; no
// new sample is taken until the last is through. The output register frees the input.
// Reset (synchronous): stores cleared, coefficient 154, no word pending.
// ----------------------------------------------------------------------------
// goertzel_tone_magnitude: integer Goertzel tone detector
// Runs the recurrence on each sample and, on the closing sample, the block
// power and its floor square root, on serial units; multiplier and divider are shared.
// ----------------------------------------------------------------------------
module goertzel_tone_magnitude #(
   parameter int SAMPLE_BITS = gtm_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [gtm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [gtm_pkg::MAG_W-1:0]    rsp_magnitude,
   input  logic                         csr_wr_en,
   input  logic [gtm_pkg::COEFF_W-1:0]  csr_wr_data
);

   localparam int                      QW     = gtm_pkg::Q_W;
   localparam int                      CW     = gtm_pkg::COEFF_W;
   localparam logic [gtm_pkg::POWER_W-1:0] POWER_SAT = '1;

   gtm_pkg::state_type           state_ff, state_in;
   logic                         go_ff, go_in;
   logic [CW-1:0]                coeff_ff, coeff_in;
   logic [QW-1:0]                q1_ff, q1_in;
   logic [QW-1:0]                q2_ff, q2_in;
   logic [QW-1:0]                sample_ff, sample_in;
   logic                         last_ff, last_in;
   logic [gtm_pkg::SQ_W-1:0]     sum_ff, sum_in;
   logic [gtm_pkg::POWER_W-1:0]  power_ff, power_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [gtm_pkg::MAG_W-1:0]    rsp_mag_ff, rsp_mag_in;

   logic                         c_neg;
   logic [CW-1:0]                c_mag;
   logic [QW-1:0]                q1_mag;
   logic [QW-1:0]                q2_mag;
   logic [QW-1:0]                quot_lo;
   logic [QW-1:0]                quot_signed;
   logic [QW-1:0]                q0;

   logic                         mul_start;
   logic                         mul_done;
   logic [gtm_pkg::MCAND_W-1:0]  mul_mcand;
   logic [QW-1:0]                mul_mplr;
   logic [gtm_pkg::PROD_W-1:0]   mul_product;

   gtm_pkg::div_cmd_type         div_cmd;
   logic                         div_done;
   logic [gtm_pkg::PROD_W-1:0]   div_quotient;

   logic                         root_start;
   logic                         root_done;
   logic [gtm_pkg::ROOT_W-1:0]   root_value;

   logic [gtm_pkg::SQ_W-1:0]     term;
   logic                         term_neg;
   logic [gtm_pkg::SQ_W:0]       pwr_plus;
   logic [gtm_pkg::SQ_W:0]       pwr_minus;
   logic [gtm_pkg::POWER_W-1:0]  pwr_clamped;
   logic                         out_load;

   // magnitudes and signs of the operands
   assign c_neg  = coeff_ff[CW-1];
   assign c_mag  = c_neg ? (~coeff_ff + 1'b1) : coeff_ff;
   assign q1_mag = q1_ff[QW-1] ? (~q1_ff + 1'b1) : q1_ff;
   assign q2_mag = q2_ff[QW-1] ? (~q2_ff + 1'b1) : q2_ff;

   // recurrence: trunc(c*q1/100) - q2 + x, wrapping to 32 bits
   assign quot_lo     = div_quotient[QW-1:0];
   assign quot_signed = (c_neg ^ q1_ff[QW-1]) ? (~quot_lo + 1'b1) : quot_lo;
   assign q0          = quot_signed - q2_ff + sample_ff;

   // block power: s -/+ trunc(|q1*q2*c|/100), clamped to 32 bits
   assign term      = div_quotient[gtm_pkg::SQ_W-1:0];
   assign term_neg  = q1_ff[QW-1] ^ q2_ff[QW-1] ^ c_neg;
   assign pwr_plus  = {1'b0, sum_ff} + {1'b0, term};
   assign pwr_minus = {1'b0, sum_ff} - {1'b0, term};

   always_comb begin
      if (term_neg) begin
         if (pwr_plus[gtm_pkg::SQ_W:gtm_pkg::POWER_W] != '0) begin
            pwr_clamped = POWER_SAT;
         end else begin
            pwr_clamped = pwr_plus[gtm_pkg::POWER_W-1:0];
         end
      end else begin
         if (pwr_minus[gtm_pkg::SQ_W]) begin
            pwr_clamped = '0;
         end else if (pwr_minus[gtm_pkg::SQ_W-1:gtm_pkg::POWER_W] != '0) begin
            pwr_clamped = POWER_SAT;
         end else begin
            pwr_clamped = pwr_minus[gtm_pkg::POWER_W-1:0];
         end
      end
   end

   // multiplier operand selection per step
   always_comb begin
      unique case (state_ff)
         gtm_pkg::ST_PWR_SQ1: begin
            mul_mcand = gtm_pkg::MCAND_W'(q1_mag);
            mul_mplr  = q1_mag;
         end
         gtm_pkg::ST_PWR_SQ2: begin
            mul_mcand = gtm_pkg::MCAND_W'(q2_mag);
            mul_mplr  = q2_mag;
         end
         gtm_pkg::ST_PWR_CQ2: begin
            mul_mcand = gtm_pkg::MCAND_W'(c_mag);
            mul_mplr  = q2_mag;
         end
         gtm_pkg::ST_PWR_CQ12: begin
            mul_mcand = mul_product[gtm_pkg::MCAND_W-1:0];
            mul_mplr  = q1_mag;
         end
         default: begin
            mul_mcand = gtm_pkg::MCAND_W'(c_mag);
            mul_mplr  = q1_mag;
         end
      endcase
   end

   // unit starts on the first cycle of each step
   assign mul_start    = go_ff & ((state_ff == gtm_pkg::ST_REC_MUL) |
                                  (state_ff == gtm_pkg::ST_PWR_SQ1) |
                                  (state_ff == gtm_pkg::ST_PWR_SQ2) |
                                  (state_ff == gtm_pkg::ST_PWR_CQ2) |
                                  (state_ff == gtm_pkg::ST_PWR_CQ12));
   assign div_cmd.start = go_ff & ((state_ff == gtm_pkg::ST_REC_DIV) |
                                   (state_ff == gtm_pkg::ST_PWR_DIV));
   assign div_cmd.wide  = (state_ff == gtm_pkg::ST_PWR_DIV);
   assign root_start    = go_ff & (state_ff == gtm_pkg::ST_ROOT);

   assign out_load = ~rsp_valid_ff | rsp_ready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      q1_in        = q1_ff;
      q2_in        = q2_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      sum_in       = sum_ff;
      power_in     = power_ff;
      rsp_mag_in   = rsp_mag_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      coeff_in     = csr_wr_en ? csr_wr_data : coeff_ff;
      unique case (state_ff)
         gtm_pkg::ST_IDLE: begin
            if (req_valid) begin
               // low SAMPLE_BITS bits, sign-extended
               sample_in = {{(QW - SAMPLE_BITS){req_sample[SAMPLE_BITS-1]}},
                            req_sample[SAMPLE_BITS-1:0]};
               last_in   = req_last;
               state_in  = gtm_pkg::ST_REC_MUL;
            end
         end
         gtm_pkg::ST_REC_MUL: begin
            if (mul_done) state_in = gtm_pkg::ST_REC_DIV;
         end
         gtm_pkg::ST_REC_DIV: begin
            if (div_done) state_in = gtm_pkg::ST_REC_SUM;
         end
         gtm_pkg::ST_REC_SUM: begin
            q2_in    = q1_ff;
            q1_in    = q0;
            state_in = last_ff ? gtm_pkg::ST_PWR_SQ1 : gtm_pkg::ST_IDLE;
         end
         gtm_pkg::ST_PWR_SQ1: begin
            if (mul_done) begin
               sum_in   = mul_product[gtm_pkg::SQ_W-1:0];
               state_in = gtm_pkg::ST_PWR_SQ2;
            end
         end
         gtm_pkg::ST_PWR_SQ2: begin
            if (mul_done) begin
               sum_in   = sum_ff + mul_product[gtm_pkg::SQ_W-1:0];
               state_in = gtm_pkg::ST_PWR_CQ2;
            end
         end
         gtm_pkg::ST_PWR_CQ2: begin
            if (mul_done) state_in = gtm_pkg::ST_PWR_CQ12;
         end
         gtm_pkg::ST_PWR_CQ12: begin
            if (mul_done) state_in = gtm_pkg::ST_PWR_DIV;
         end
         gtm_pkg::ST_PWR_DIV: begin
            if (div_done) state_in = gtm_pkg::ST_PWR_SUM;
         end
         gtm_pkg::ST_PWR_SUM: begin
            // stores cleared for the next block
            power_in = pwr_clamped;
            q1_in    = '0;
            q2_in    = '0;
            state_in = gtm_pkg::ST_ROOT;
         end
         gtm_pkg::ST_ROOT: begin
            if (root_done) state_in = gtm_pkg::ST_OUT;
         end
         gtm_pkg::ST_OUT: begin
            if (out_load) begin
               rsp_mag_in   = gtm_pkg::MAG_W'(root_value);
               rsp_valid_in = 1'b1;
               state_in     = gtm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gtm_pkg::ST_IDLE;
         end
      endcase
      go_in = (state_in != state_ff);
   end

   // control and stores
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gtm_pkg::ST_IDLE;
         go_ff        <= 1'b0;
         coeff_ff     <= gtm_pkg::COEFF_RESET;
         q1_ff        <= '0;
         q2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         coeff_ff     <= coeff_in;
         q1_ff        <= q1_in;
         q2_ff        <= q2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      last_ff    <= last_in;
      sum_ff     <= sum_in;
      power_ff   <= power_in;
      rsp_mag_ff <= rsp_mag_in;
   end

   gtm_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplr    (mul_mplr),
      .done    (mul_done),
      .product (mul_product)
   );

   gtm_div100 u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (mul_product),
      .done     (div_done),
      .quotient (div_quotient)
   );

   gtm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (power_ff),
      .done     (root_done),
      .root     (root_value)
   );

   assign req_ready     = (state_ff == gtm_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_magnitude = rsp_mag_ff;

endmodule

@@ tb/sv/tb_goertzel_tone_magnitude.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_goertzel_tone_magnitude: self-checking bench for the Goertzel tone block
// Sends sample words in blocks and predicts each block's floor square root of
// tone power with its own integer Goertzel model. It compares every magnitude
// word in order, under idling on both sides and several coefficient settings.
// ----------------------------------------------------------------------------
module tb_goertzel_tone_magnitude;

   localparam int RUN_LIMIT   = 2_500_000;   // cycles before the run is abandoned
   localparam int SETTLE_GAP  = 100;         // covers a sample still in the recurrence
   localparam int END_GAP     = 320;         // covers a closing sample's full latency
   localparam int PHASE_WORDS = 100;         // samples per coefficient setting, at least

   logic                               clock;
   logic                               reset         = 1'b1;
   logic                               req_valid     = 1'b0;
   logic                               req_ready;
   logic signed [15:0]                 req_sample    = '0;
   logic                               req_last      = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_ready     = 1'b0;
   logic [gtm_pkg::MAG_W-1:0]          rsp_magnitude;
   logic                               csr_wr_en     = 1'b0;
   logic [gtm_pkg::COEFF_W-1:0]        csr_wr_data   = '0;

   // model state: coefficient and the two recurrence stores
   logic signed [gtm_pkg::COEFF_W-1:0] tone_coeff;
   logic signed [31:0]                 tone_q1;
   logic signed [31:0]                 tone_q2;
   logic [gtm_pkg::MAG_W-1:0]          magnitude_due[$];
   logic [gtm_pkg::MAG_W-1:0]          due_word;

   int tx_idle_pct   = 0;
   int rx_idle_pct   = 0;
   int cycle_count   = 0;
   int fail_count    = 0;
   int samples_sent  = 0;
   int blocks_sent   = 0;
   int words_checked = 0;
   int coeff_writes  = 0;

   // coefficient corners, including codes beyond the nominal +/-200
   logic signed [gtm_pkg::COEFF_W-1:0] coeff_corner [6] =
      '{9'sd200, -9'sd200, -9'sd256, 9'sd255, 9'sd0, 9'sd154};

   goertzel_tone_magnitude dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_magnitude (rsp_magnitude),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycle_count, magnitude_due.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // floor square root, one result bit at a time from the top
   function automatic logic [gtm_pkg::MAG_W-1:0] floor_root(logic [31:0] power);
      logic [31:0] root;
      logic [31:0] trial;
      root = '0;
      for (int b = gtm_pkg::MAG_W - 1; b >= 0; b--) begin
         trial = root | (32'd1 << b);
         if (trial * trial <= power) root = trial;
      end
      return root[gtm_pkg::MAG_W-1:0];
   endfunction

   // advance the recurrence on one accepted sample; a closing sample queues its magnitude
   task automatic goertzel_step(input logic signed [15:0] x, input logic closing);
      logic signed [63:0] cw, q1w, q2w, xw, q0;
      logic signed [95:0] a, b, c, pw;
      logic [31:0]        power;
      cw  = tone_coeff;
      q1w = tone_q1;
      q2w = tone_q2;
      xw  = x;
      q0  = (cw * q1w) / 64'sd100 - q2w + xw;   // truncates toward zero
      tone_q2 = tone_q1;
      tone_q1 = q0[31:0];                       // wraps to 32 bits
      if (closing) begin
         a  = tone_q1;
         b  = tone_q2;
         c  = tone_coeff;
         pw = a * a + b * b - (a * b * c) / 96'sd100;
         if (pw <= 0)
            power = '0;
         else if (pw > 96'sd4294967295)
            power = '1;
         else
            power = pw[31:0];
         magnitude_due.push_back(floor_root(power));
         tone_q1 = '0;
         tone_q2 = '0;
      end
   endtask

   // magnitude checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (magnitude_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected magnitude word %0d at cycle %0d",
                        rsp_magnitude, cycle_count);
         end else begin
            due_word = magnitude_due.pop_front();
            words_checked++;
            if (rsp_magnitude !== due_word) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("magnitude mismatch at cycle %0d: expected %0d, got %0d",
                           cycle_count, due_word, rsp_magnitude);
            end
         end
      end
   end

   // send one sample word, with random idle cycles before it
   task automatic send_sample(input logic signed [15:0] x, input logic closing);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= x;
      req_last   <= closing;
      do @(posedge clock); while (!req_ready);
      goertzel_step(x, closing);
      samples_sent++;
      if (closing) blocks_sent++;
   endtask

   // hold the input off until every queued magnitude word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (magnitude_due.size() != 0) @(posedge clock);
   endtask

   // coefficient write, only once the block has gone quiet
   task automatic write_coeff(input logic signed [gtm_pkg::COEFF_W-1:0] value);
      wait_drained();
      repeat (SETTLE_GAP) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      tone_coeff = value;
      coeff_writes++;
   endtask

   // random sample: rails, small values near zero, or any code
   function automatic logic signed [15:0] pick_sample();
      unique case ($urandom_range(7))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return 16'($urandom_range(0, 63)) - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   // one-sample blocks at the sample rails and at zero
   task automatic test_single_sample_blocks();
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh7fff, 1'b1);
      send_sample(16'sh0000, 1'b1);
   endtask

   // coefficient changed between samples of an open block
   task automatic test_coeff_change_mid_block();
      send_sample(16'sh7fff, 1'b0);
      send_sample(-16'sd12345, 1'b0);
      write_coeff(-9'sd200);
      send_sample(16'sh4000, 1'b1);
   endtask

   // runaway coefficient with full-scale input: stores wrap, power saturates or clamps
   task automatic test_recurrence_overflow();
      write_coeff(9'sd255);
      for (int i = 0; i < 18; i++)
         send_sample(16'sh7fff, i == 17);
   endtask

   // random blocks under one idling pattern, across four coefficient settings
   task automatic test_random_blocks(input int tx_pct, input int rx_pct, input int phase);
      int sent;
      int len;
      logic signed [gtm_pkg::COEFF_W-1:0] value;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (int k = 0; k < 4; k++) begin
         if (k % 2 == 0)
            value = coeff_corner[(phase * 2 + k / 2) % 6];
         else
            value = gtm_pkg::COEFF_W'($urandom_range(0, 511));
         write_coeff(value);
         sent = 0;
         while (sent < PHASE_WORDS) begin
            // mostly short blocks, now and then a long one to grow the stores
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 10);
            for (int i = 0; i < len; i++)
               send_sample(pick_sample(), i == len - 1);
            sent += len;
            if ($urandom_range(14) == 0) wait_drained();
         end
      end
   endtask

   // test sequence
   initial begin
      tone_coeff = gtm_pkg::COEFF_RESET;
      tone_q1    = '0;
      tone_q2    = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tx_idle_pct = 11;
      rx_idle_pct = 64;
      test_single_sample_blocks();
      test_coeff_change_mid_block();
      test_recurrence_overflow();

      test_random_blocks(11, 64, 0);
      test_random_blocks(64, 11, 1);
      test_random_blocks(0, 0, 2);

      wait_drained();
      repeat (END_GAP) @(posedge clock);

      $display("covered %0d samples in %0d blocks over %0d coefficient writes",
               samples_sent, blocks_sent, coeff_writes);
      $display("%0d magnitude words checked, %0d failures", words_checked, fail_count);
      if (fail_count == 0 && magnitude_due.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ sim.f @@
design/gtm_pkg.sv
design/gtm_mul.sv
design/gtm_div100.sv
design/gtm_sqrt.sv
design/goertzel_tone_magnitude.sv
tb/sv/tb_goertzel_tone_magnitude.sv
